/* rtl/mecanum_inverse_kinematics_defines.svh */
// assertion macros for the mecanum inverse kinematics checker
// no dependencies
`ifndef MECANUM_INVERSE_KINEMATICS_DEFINES_SVH
`define MECANUM_INVERSE_KINEMATICS_DEFINES_SVH

// same-cycle implication
`define MIK_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MIK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/mik_pkg.sv */
// shared constants, types and functions of the mecanum inverse kinematics block
// no dependencies
`timescale 1ns / 1ps

package mik_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int ANGLE_WIDTH_DEF = 16;

   localparam int CSR_DATA_W  = 31;
   localparam int CSR_INDEX_W = 3;
   localparam int REV_W       = 4;
   localparam int DEN_W       = 62;
   localparam int TRIG_W      = 31;
   localparam int POLY_W      = 32;
   localparam int LATENCY     = 113;

   localparam logic [CSR_DATA_W-1:0] WHEEL_RADIUS_RST = 31'd6554;
   localparam logic [CSR_DATA_W-1:0] BODY_LENGTH_RST  = 31'd32768;
   localparam logic [CSR_DATA_W-1:0] BODY_WIDTH_RST   = 31'd16384;
   localparam logic [CSR_DATA_W-1:0] SPEED_LIMIT_RST  = 31'd6553600;
   localparam logic [CSR_DATA_W-1:0] GEAR_RATIO_RST   = 31'd65536;

   localparam logic [POLY_W-1:0] SC1 = 32'd1686629713;
   localparam logic [POLY_W-1:0] SC3 = 32'd693598668;
   localparam logic [POLY_W-1:0] SC5 = 32'd85569306;
   localparam logic [POLY_W-1:0] SC7 = 32'd5026994;
   localparam logic [POLY_W-1:0] SC9 = 32'd172272;
   localparam logic [TRIG_W-1:0] Q30_ONE = 31'h4000_0000;

   localparam logic [DEN_W-1:0] SPEED_CAP = {DEN_W{1'b1}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WHEEL_RADIUS,
      CSR_BODY_LENGTH,
      CSR_BODY_WIDTH,
      CSR_SPEED_LIMIT,
      CSR_GEAR_RATIO,
      CSR_REVERSE_MASK
   } csr_index_type;

   typedef struct packed {
      logic              neg;
      logic [TRIG_W-1:0] z;
   } trig_fold_type;

   // fold a 32-bit binary angle into the first quadrant
   function automatic trig_fold_type trig_fold(input logic [31:0] a);
      trig_fold_type f;
      logic [31:0]   d;
      unique case (a[31:30])
         2'd0: begin d = a;                   f.neg = 1'b0; end
         2'd1: begin d = 32'h8000_0000 - a;   f.neg = 1'b0; end
         2'd2: begin d = a - 32'h8000_0000;   f.neg = 1'b1; end
         default: begin d = 32'h0 - a;        f.neg = 1'b1; end
      endcase
      f.z = d[TRIG_W-1:0];
      return f;
   endfunction

   function automatic logic [POLY_W-1:0] horner(input logic [TRIG_W-1:0] z2,
                                                input logic [POLY_W-1:0] p,
                                                input logic [POLY_W-1:0] c);
      logic [TRIG_W+POLY_W-1:0] prod;
      prod = (TRIG_W+POLY_W)'(z2) * (TRIG_W+POLY_W)'(p);
      return c - POLY_W'(prod >> 30);
   endfunction

   function automatic logic [TRIG_W-1:0] trig_final(input logic [TRIG_W-1:0] z,
                                                    input logic [POLY_W-1:0] p);
      logic [TRIG_W+POLY_W-1:0] prod;
      logic [POLY_W:0]          s;
      prod = (TRIG_W+POLY_W)'(z) * (TRIG_W+POLY_W)'(p);
      s = (POLY_W+1)'(prod >> 30);
      return (s > (POLY_W+1)'(Q30_ONE)) ? Q30_ONE : s[TRIG_W-1:0];
   endfunction

endpackage

/* rtl/mecanum_inverse_kinematics.sv */
// four-wheel mecanum inverse kinematics, fixed point, fully pipelined
// depends on mik_pkg and mik_div
//
// usage:
//   an item (req_vel_x, req_vel_y, req_yaw_rate, req_heading) is taken at a rising
//   edge where start is high and busy is low; busy is high only during reset.
//   one item may enter every cycle.
//   the result item appears on the rsp_ ports for one cycle with rsp_valid high;
//   items come out in request order.
//   the two dividers form most of the pipeline, one quotient bit per stage: 63 stages
//   for the wheel divide by radius times gear ratio, 32 stages for the limit
//   scaling, plus the rotate, mix and max stages.
//   the receiver cannot stall, so nothing is held back.
//   reset clears all valid bits (items in flight are dropped) and loads the
//   register defaults.
//   csr_write_en with csr_index and csr_wdata writes one register per cycle;
//   write only while no item is in flight.
`timescale 1ns / 1ps

module mecanum_inverse_kinematics #(
   parameter int VALUE_WIDTH = mik_pkg::VALUE_WIDTH_DEF,
   parameter int ANGLE_WIDTH = mik_pkg::ANGLE_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [VALUE_WIDTH-1:0]      req_vel_x,
   input  logic signed [VALUE_WIDTH-1:0]      req_vel_y,
   input  logic signed [VALUE_WIDTH-1:0]      req_yaw_rate,
   input  logic signed [ANGLE_WIDTH-1:0]      req_heading,
   input  logic                               csr_write_en,
   input  logic [mik_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mik_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                               rsp_valid,
   output logic signed [VALUE_WIDTH-1:0]      rsp_speed_front_left,
   output logic signed [VALUE_WIDTH-1:0]      rsp_speed_front_right,
   output logic signed [VALUE_WIDTH-1:0]      rsp_speed_rear_left,
   output logic signed [VALUE_WIDTH-1:0]      rsp_speed_rear_right,
   output logic                               rsp_limited
);

   import mik_pkg::*;

   localparam int VW  = VALUE_WIDTH;
   localparam int LO  = VW / 2;
   localparam int HI  = VW - LO;
   localparam int YW  = VW + 16;
   localparam int XW  = (YW > 64) ? YW : 64;
   localparam int RW  = (YW > 62) ? 62 : YW;
   localparam int TW  = ((VW + 3 > RW + 1) ? VW + 3 : RW + 1) + 1;
   localparam int NW1 = TW + 32;
   localparam int NW2 = DEN_W + CSR_DATA_W;
   localparam int PW2 = DEN_W + 2;
   localparam logic [XW-1:0] YAW_CAP = XW'(64'h2000_0000_0000_0000);
   localparam logic [DEN_W-1:0] POS_CAP = (DEN_W'(1) << (VW - 1)) - DEN_W'(1);
   localparam logic [DEN_W-1:0] NEG_CAP = DEN_W'(1) << (VW - 1);

   // configuration
   logic [CSR_DATA_W-1:0] wheel_radius_ff, body_length_ff, body_width_ff;
   logic [CSR_DATA_W-1:0] speed_limit_ff, gear_ratio_ff;
   logic [REV_W-1:0]      reverse_mask_ff;
   logic [CSR_DATA_W:0]   k_ff;
   logic [DEN_W-1:0]      den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_radius_ff <= WHEEL_RADIUS_RST;
         body_length_ff  <= BODY_LENGTH_RST;
         body_width_ff   <= BODY_WIDTH_RST;
         speed_limit_ff  <= SPEED_LIMIT_RST;
         gear_ratio_ff   <= GEAR_RATIO_RST;
         reverse_mask_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_WHEEL_RADIUS: wheel_radius_ff <= csr_wdata;
            CSR_BODY_LENGTH:  body_length_ff  <= csr_wdata;
            CSR_BODY_WIDTH:   body_width_ff   <= csr_wdata;
            CSR_SPEED_LIMIT:  speed_limit_ff  <= csr_wdata;
            CSR_GEAR_RATIO:   gear_ratio_ff   <= csr_wdata;
            CSR_REVERSE_MASK: reverse_mask_ff <= csr_wdata[REV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= (CSR_DATA_W+1)'(body_length_ff) + (CSR_DATA_W+1)'(body_width_ff);
      den_ff <= DEN_W'(wheel_radius_ff) * DEN_W'(gear_ratio_ff);
   end

   assign busy = reset;

   // front end: angle fold, sine/cosine polynomial, rotation, mixing
   logic              v_ff [1:12];
   logic [31:0]       ang;
   trig_fold_type     fold [0:1];
   logic [TRIG_W-1:0] z_ff    [1:6][0:1];
   logic              tneg_ff [1:7][0:1];
   logic [TRIG_W-1:0] z2_ff   [2:5][0:1];
   logic [POLY_W-1:0] p_ff    [3:6][0:1];
   logic [TRIG_W-1:0] trig_ff [0:1];
   logic [VW-1:0]     magx_ff [1:7];
   logic [VW-1:0]     magy_ff [1:7];
   logic [VW-1:0]     magw_ff [1:7];
   logic              sx_ff [1:7];
   logic              sy_ff [1:7];
   logic              sw_ff [1:7];
   logic [VW-1:0]     pm [0:3];
   logic [TRIG_W-1:0] pt [0:3];
   logic [LO+TRIG_W-1:0] plo_ff [0:3];
   logic [HI+TRIG_W-1:0] phi_ff [0:3];
   logic              pneg_ff [0:3];
   logic [LO+32:0]    ylo_ff;
   logic [HI+32:0]    yhi_ff;
   logic              wneg_ff;
   logic [VW+TRIG_W-1:0] tprod [0:3];
   logic [VW:0]       tmag  [0:3];
   logic signed [VW:0] tp_ff [0:3];
   logic [VW+32:0]    yprod;
   logic [XW-1:0]     ywide;
   logic [RW:0]       rotmag;
   logic signed [RW:0] rot9_ff, rot10_ff;
   logic signed [VW+1:0] vx_ff, vy_ff;
   logic signed [TW-1:0] term_ff [0:3];
   logic [TW-1:0]     mag12_ff [0:3];
   logic              neg12_ff [0:3];

   assign ang     = 32'(req_heading) << (32 - ANGLE_WIDTH);
   assign fold[0] = trig_fold(ang);
   assign fold[1] = trig_fold(ang + 32'h4000_0000);

   // product order: vx*cos, vy*sin, vy*cos, vx*sin
   always_comb begin
      pm[0] = magx_ff[7]; pt[0] = trig_ff[1];
      pm[1] = magy_ff[7]; pt[1] = trig_ff[0];
      pm[2] = magy_ff[7]; pt[2] = trig_ff[1];
      pm[3] = magx_ff[7]; pt[3] = trig_ff[0];
      for (int i = 0; i < 4; i++) begin
         tprod[i] = ((VW+TRIG_W)'(phi_ff[i]) << LO) + (VW+TRIG_W)'(plo_ff[i]);
         tmag[i]  = {1'b0, VW'(tprod[i] >> 30)};
      end
      yprod  = ((VW+33)'(yhi_ff) << LO) + (VW+33)'(ylo_ff);
      ywide  = XW'(YW'(yprod >> 16));
      rotmag = {1'b0, RW'((ywide > YAW_CAP) ? YAW_CAP : ywide)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= 12; k++) v_ff[k] <= 1'b0;
      end else begin
         v_ff[1] <= start && !busy;
         for (int k = 2; k <= 12; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         z_ff[1][l]    <= fold[l].z;
         tneg_ff[1][l] <= fold[l].neg;
         z2_ff[2][l]   <= TRIG_W'(((2*TRIG_W)'(z_ff[1][l]) * (2*TRIG_W)'(z_ff[1][l])) >> 30);
         for (int k = 2; k <= 6; k++) z_ff[k][l] <= z_ff[k-1][l];
         for (int k = 2; k <= 7; k++) tneg_ff[k][l] <= tneg_ff[k-1][l];
         for (int k = 3; k <= 5; k++) z2_ff[k][l] <= z2_ff[k-1][l];
         p_ff[3][l]  <= horner(z2_ff[2][l], SC9, SC7);
         p_ff[4][l]  <= horner(z2_ff[3][l], p_ff[3][l], SC5);
         p_ff[5][l]  <= horner(z2_ff[4][l], p_ff[4][l], SC3);
         p_ff[6][l]  <= horner(z2_ff[5][l], p_ff[5][l], SC1);
         trig_ff[l]  <= trig_final(z_ff[6][l], p_ff[6][l]);
      end

      magx_ff[1] <= req_vel_x[VW-1] ? VW'(-req_vel_x) : VW'(req_vel_x);
      magy_ff[1] <= req_vel_y[VW-1] ? VW'(-req_vel_y) : VW'(req_vel_y);
      magw_ff[1] <= req_yaw_rate[VW-1] ? VW'(-req_yaw_rate) : VW'(req_yaw_rate);
      sx_ff[1]   <= req_vel_x[VW-1];
      sy_ff[1]   <= req_vel_y[VW-1];
      sw_ff[1]   <= req_yaw_rate[VW-1];
      for (int k = 2; k <= 7; k++) begin
         magx_ff[k] <= magx_ff[k-1];
         magy_ff[k] <= magy_ff[k-1];
         magw_ff[k] <= magw_ff[k-1];
         sx_ff[k]   <= sx_ff[k-1];
         sy_ff[k]   <= sy_ff[k-1];
         sw_ff[k]   <= sw_ff[k-1];
      end

      // partial products
      for (int i = 0; i < 4; i++) begin
         plo_ff[i] <= (LO+TRIG_W)'(pm[i][LO-1:0]) * (LO+TRIG_W)'(pt[i]);
         phi_ff[i] <= (HI+TRIG_W)'(pm[i][VW-1:LO]) * (HI+TRIG_W)'(pt[i]);
      end
      pneg_ff[0] <= sx_ff[7] ^ tneg_ff[7][1];
      pneg_ff[1] <= sy_ff[7] ^ tneg_ff[7][0];
      pneg_ff[2] <= sy_ff[7] ^ tneg_ff[7][1];
      pneg_ff[3] <= sx_ff[7] ^ tneg_ff[7][0];
      ylo_ff  <= (LO+33)'(magw_ff[7][LO-1:0]) * (LO+33)'(k_ff);
      yhi_ff  <= (HI+33)'(magw_ff[7][VW-1:LO]) * (HI+33)'(k_ff);
      wneg_ff <= sw_ff[7];

      // signed trig products and yaw term
      for (int i = 0; i < 4; i++) tp_ff[i] <= pneg_ff[i] ? (VW+1)'(-tmag[i]) : tmag[i];
      rot9_ff <= wneg_ff ? (RW+1)'(-rotmag) : rotmag;

      // rotated velocity
      vx_ff    <= (VW+2)'(tp_ff[0]) + (VW+2)'(tp_ff[1]);
      vy_ff    <= (VW+2)'(tp_ff[2]) - (VW+2)'(tp_ff[3]);
      rot10_ff <= rot9_ff;

      // wheel mixing
      term_ff[0] <= TW'(vx_ff) - TW'(vy_ff) + TW'(rot10_ff);
      term_ff[1] <= TW'(vx_ff) + TW'(vy_ff) + TW'(rot10_ff);
      term_ff[2] <= TW'(vx_ff) + TW'(vy_ff) - TW'(rot10_ff);
      term_ff[3] <= TW'(vx_ff) - TW'(vy_ff) - TW'(rot10_ff);

      for (int i = 0; i < 4; i++) begin
         mag12_ff[i] <= term_ff[i][TW-1] ? TW'(-term_ff[i]) : TW'(term_ff[i]);
         neg12_ff[i] <= term_ff[i][TW-1] ^ reverse_mask_ff[i];
      end
   end

   // wheel divide by radius times gear ratio
   logic             d1_valid [0:3];
   logic [DEN_W-1:0] d1_quo   [0:3];
   logic             d1_ovf   [0:3];
   logic             d1_neg   [0:3];

   for (genvar i = 0; i < 4; i++) begin : g_wheel_div
      mik_div #(
         .NUM_W (NW1),
         .DEN_W (DEN_W),
         .QUO_W (DEN_W),
         .PAY_W (1)
      ) u_wheel_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v_ff[12]),
         .in_num    ({mag12_ff[i], 32'h0}),
         .in_den    (den_ff),
         .in_pay    (neg12_ff[i]),
         .out_valid (d1_valid[i]),
         .out_quo   (d1_quo[i]),
         .out_ovf   (d1_ovf[i]),
         .out_pay   (d1_neg[i])
      );
   end

   // saturate, max search, limit product
   logic             va_ff, vb_ff, vc_ff, vd_ff, ve_ff;
   logic [DEN_W-1:0] ma_ff [0:3];
   logic [DEN_W-1:0] mb_ff [0:3];
   logic [DEN_W-1:0] mc_ff [0:3];
   logic [DEN_W-1:0] md_ff [0:3];
   logic [DEN_W-1:0] me_ff [0:3];
   logic             na_ff [0:3];
   logic             nb_ff [0:3];
   logic             nc_ff [0:3];
   logic             nd_ff [0:3];
   logic             ne_ff [0:3];
   logic [DEN_W-1:0] max01_ff, max23_ff, maxc_ff, maxd_ff, maxe_ff;
   logic             limd_ff, lime_ff;
   logic [DEN_W-1:0] slo_ff [0:3];
   logic [DEN_W-1:0] shi_ff [0:3];
   logic [NW2-1:0]   prode_ff [0:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         va_ff <= d1_valid[0] & d1_valid[1] & d1_valid[2] & d1_valid[3];
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         ma_ff[i] <= d1_ovf[i] ? SPEED_CAP : d1_quo[i];
         na_ff[i] <= d1_neg[i];
         mb_ff[i] <= ma_ff[i];
         nb_ff[i] <= na_ff[i];
         mc_ff[i] <= mb_ff[i];
         nc_ff[i] <= nb_ff[i];
         md_ff[i] <= mc_ff[i];
         nd_ff[i] <= nc_ff[i];
         me_ff[i] <= md_ff[i];
         ne_ff[i] <= nd_ff[i];
         slo_ff[i] <= DEN_W'(mc_ff[i][CSR_DATA_W-1:0]) * DEN_W'(speed_limit_ff);
         shi_ff[i] <= DEN_W'(mc_ff[i][DEN_W-1:CSR_DATA_W]) * DEN_W'(speed_limit_ff);
         prode_ff[i] <= (NW2'(shi_ff[i]) << CSR_DATA_W) + NW2'(slo_ff[i]);
      end
      max01_ff <= (ma_ff[1] > ma_ff[0]) ? ma_ff[1] : ma_ff[0];
      max23_ff <= (ma_ff[3] > ma_ff[2]) ? ma_ff[3] : ma_ff[2];
      maxc_ff  <= (max23_ff > max01_ff) ? max23_ff : max01_ff;
      maxd_ff  <= maxc_ff;
      limd_ff  <= maxc_ff > DEN_W'(speed_limit_ff);
      maxe_ff  <= maxd_ff;
      lime_ff  <= limd_ff;
   end

   // limit scaling divide by the largest wheel
   logic                  d2_valid [0:3];
   logic [CSR_DATA_W-1:0] d2_quo   [0:3];
   logic                  d2_ovf   [0:3];
   logic [PW2-1:0]        d2_pay   [0:3];

   for (genvar i = 0; i < 4; i++) begin : g_limit_div
      mik_div #(
         .NUM_W (NW2),
         .DEN_W (DEN_W),
         .QUO_W (CSR_DATA_W),
         .PAY_W (PW2)
      ) u_limit_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (ve_ff),
         .in_num    (prode_ff[i]),
         .in_den    (maxe_ff),
         .in_pay    ({ne_ff[i], lime_ff, me_ff[i]}),
         .out_valid (d2_valid[i]),
         .out_quo   (d2_quo[i]),
         .out_ovf   (d2_ovf[i]),
         .out_pay   (d2_pay[i])
      );
   end

   // output saturation and sign
   logic [DEN_W-1:0] fmag [0:3];
   logic [DEN_W-1:0] fcap [0:3];
   logic [VW-1:0]    fout [0:3];
   logic             f_valid;
   logic             out_valid_ff, out_limited_ff;
   logic [VW-1:0]    speed_ff [0:3];

   always_comb begin
      f_valid = d2_valid[0] & d2_valid[1] & d2_valid[2] & d2_valid[3];
      for (int i = 0; i < 4; i++) begin
         // the scaled value never exceeds the limit, so no quotient overflow
         fmag[i] = (d2_pay[i][DEN_W] && !d2_ovf[i]) ? DEN_W'(d2_quo[i]) : d2_pay[i][DEN_W-1:0];
         if (d2_pay[i][DEN_W+1]) begin
            fcap[i] = (fmag[i] > NEG_CAP) ? NEG_CAP : fmag[i];
            fout[i] = VW'(DEN_W'(0) - fcap[i]);
         end else begin
            fcap[i] = (fmag[i] > POS_CAP) ? POS_CAP : fmag[i];
            fout[i] = VW'(fcap[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         out_limited_ff <= 1'b0;
      end else begin
         out_valid_ff   <= f_valid;
         out_limited_ff <= f_valid & d2_pay[0][DEN_W];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) speed_ff[i] <= fout[i];
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_limited           = out_limited_ff;
   assign rsp_speed_front_left  = speed_ff[0];
   assign rsp_speed_front_right = speed_ff[1];
   assign rsp_speed_rear_left   = speed_ff[2];
   assign rsp_speed_rear_right  = speed_ff[3];

endmodule

/* rtl/mik_div.sv */
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// no dependencies
`timescale 1ns / 1ps

module mik_div #(
   parameter int NUM_W = 94,
   parameter int DEN_W = 62,
   parameter int QUO_W = 62,
   parameter int PAY_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [PAY_W-1:0] in_pay,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo,
   output logic             out_ovf,
   output logic [PAY_W-1:0] out_pay
);

   logic             valid_ff [0:QUO_W];
   logic [DEN_W-1:0] rem_ff   [0:QUO_W];
   logic [QUO_W-1:0] low_ff   [0:QUO_W];
   logic [QUO_W-1:0] quo_ff   [0:QUO_W];
   logic [DEN_W-1:0] den_ff   [0:QUO_W];
   logic             ovf_ff   [0:QUO_W];
   logic [PAY_W-1:0] pay_ff   [0:QUO_W];
   logic [DEN_W:0]   trial    [1:QUO_W];
   logic             ge       [1:QUO_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QUO_W; k++) valid_ff[k] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k <= QUO_W; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= DEN_W'(in_num[NUM_W-1:QUO_W]);
      ovf_ff[0] <= in_num[NUM_W-1:QUO_W] >= in_den;
      low_ff[0] <= in_num[QUO_W-1:0];
      quo_ff[0] <= '0;
      den_ff[0] <= in_den;
      pay_ff[0] <= in_pay;
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
      always_comb begin
         trial[k] = {rem_ff[k-1], low_ff[k-1][QUO_W-1]};
         ge[k]    = trial[k] >= {1'b0, den_ff[k-1]};
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= ge[k] ? DEN_W'(trial[k] - {1'b0, den_ff[k-1]}) : DEN_W'(trial[k]);
         low_ff[k] <= low_ff[k-1] << 1;
         quo_ff[k] <= QUO_W'({quo_ff[k-1], ge[k]});
         den_ff[k] <= den_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
         pay_ff[k] <= pay_ff[k-1];
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign out_quo   = quo_ff[QUO_W];
   assign out_ovf   = ovf_ff[QUO_W];
   assign out_pay   = pay_ff[QUO_W];

endmodule

/* rtl/mik_checker.sv */
// port-level checks for the mecanum inverse kinematics block, bound to the top level
// depends on mik_pkg and mecanum_inverse_kinematics_defines.svh
`timescale 1ns / 1ps
`include "mecanum_inverse_kinematics_defines.svh"

module mik_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_limited
);

   import mik_pkg::*;

   // every result item comes from an item taken a fixed latency earlier
   `MIK_ASSERT_SAME(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, LATENCY), "result item without a matching request")
   `MIK_ASSERT_NEXT(a_reset_flushes, clock, 1'b0, reset, !rsp_valid, "result item right after reset")
   `MIK_ASSERT_SAME(a_limited_strobe, clock, reset, rsp_limited, rsp_valid, "limited flag outside a result item")

endmodule

bind mecanum_inverse_kinematics mik_checker u_mik_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_limited (rsp_limited)
);

/* bench/tb_top.sv */
// self-checking bench for mecanum_inverse_kinematics: a queue-fed driver, a monitor
// with an inline fixed-point predictor, and register phases with extreme settings
// depends on mik_pkg and the mecanum_inverse_kinematics rtl
`timescale 1ns / 1ps

module tb_top;
   import mik_pkg::*;

   typedef struct {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] yaw_rate;
      logic signed [15:0] heading;
   } velocity_cmd_type;

   typedef struct {
      logic signed [31:0] fl;
      logic signed [31:0] fr;
      logic signed [31:0] rl;
      logic signed [31:0] rr;
      logic               lim;
   } wheel_speeds_type;

   localparam logic [63:0] MAG_CAP = (64'd1 << 62) - 64'd1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_vel_x = '0, req_vel_y = '0, req_yaw_rate = '0;
   logic signed [15:0] req_heading = '0;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic rsp_valid, rsp_limited;
   logic signed [31:0] rsp_speed_front_left, rsp_speed_front_right;
   logic signed [31:0] rsp_speed_rear_left, rsp_speed_rear_right;

   velocity_cmd_type pending_cmds[$];
   wheel_speeds_type expected_speeds[$];
   logic [63:0] radius_q = 64'd6554, length_q = 64'd32768, width_q = 64'd16384;
   logic [63:0] limit_q = 64'd6553600, gear_q = 64'd65536;
   logic [3:0] rev_mask = 4'd0;
   logic taken = 1'b0;
   logic quiet = 1'b0;
   int gap = 0;
   int fails = 0;

   mecanum_inverse_kinematics u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y), .req_yaw_rate(req_yaw_rate),
      .req_heading(req_heading), .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .rsp_valid(rsp_valid),
      .rsp_speed_front_left(rsp_speed_front_left),
      .rsp_speed_front_right(rsp_speed_front_right),
      .rsp_speed_rear_left(rsp_speed_rear_left),
      .rsp_speed_rear_right(rsp_speed_rear_right), .rsp_limited(rsp_limited)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      return v < 0 ? 64'd0 - 64'(v) : 64'(v);
   endfunction

   function automatic logic [63:0] sine_mag(input logic [31:0] a, output logic neg);
      logic [63:0] z, z2, p;
      case (a[31:30])
         2'd0: begin z = {32'd0, a}; neg = 1'b0; end
         2'd1: begin z = 64'h8000_0000 - {32'd0, a}; neg = 1'b0; end
         2'd2: begin z = {32'd0, a} - 64'h8000_0000; neg = 1'b1; end
         default: begin z = 64'h1_0000_0000 - {32'd0, a}; neg = 1'b1; end
      endcase
      z2 = (z * z) >> 30;
      p = 64'(SC7) - ((z2 * 64'(SC9)) >> 30);
      p = 64'(SC5) - ((z2 * p) >> 30);
      p = 64'(SC3) - ((z2 * p) >> 30);
      p = 64'(SC1) - ((z2 * p) >> 30);
      p = (z * p) >> 30;
      if (p > 64'(Q30_ONE)) p = 64'(Q30_ONE);
      if (p == 0) neg = 1'b0;
      return p;
   endfunction

   function automatic logic signed [63:0] trig_prod(input logic signed [63:0] v,
                                                    input logic [63:0] t, input logic tn);
      logic [127:0] pr;
      logic [63:0] m;
      pr = {64'd0, abs64(v)} * {64'd0, t};
      m = pr[93:30];
      return ((v < 0) != tn) ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic [63:0] scale_sat(input logic [63:0] a, input logic [63:0] b,
                                             input logic [63:0] d);
      logic [127:0] q;
      if (d == 0) return MAG_CAP;
      q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
      return (q > {64'd0, MAG_CAP}) ? MAG_CAP : q[63:0];
   endfunction

   function automatic wheel_speeds_type predict_speeds(input velocity_cmd_type c);
      wheel_speeds_type r;
      logic [31:0] ang;
      logic sn, cn;
      logic [63:0] s, co, rm, maxm, v;
      logic signed [63:0] vx, vy, rot, vxi, vyi, w;
      logic signed [63:0] t[4];
      logic [63:0] m[4];
      logic neg[4];
      logic [31:0] o[4];
      vxi = c.vel_x;
      vyi = c.vel_y;
      w = c.yaw_rate;
      ang = {c.heading, 16'd0};
      s = sine_mag(ang, sn);
      co = sine_mag(ang + 32'h4000_0000, cn);
      vx = trig_prod(vxi, co, cn) + trig_prod(vyi, s, sn);
      vy = trig_prod(vyi, co, cn) - trig_prod(vxi, s, sn);
      rm = 64'(({64'd0, abs64(w)} * {64'd0, length_q + width_q}) >> 16);
      if (rm > (64'd1 << 61)) rm = 64'd1 << 61;
      rot = (w < 0) ? -$signed(rm) : $signed(rm);
      t[0] = vx - vy + rot;
      t[1] = vx + vy + rot;
      t[2] = vx + vy - rot;
      t[3] = vx - vy - rot;
      maxm = 64'd0;
      for (int i = 0; i < 4; i++) begin
         m[i] = scale_sat(abs64(t[i]), 64'd1 << 32, radius_q * gear_q);
         neg[i] = (t[i] < 0) != rev_mask[i];
         if (m[i] > maxm) maxm = m[i];
      end
      r.lim = maxm > limit_q;
      for (int i = 0; i < 4; i++) begin
         v = r.lim ? scale_sat(m[i], limit_q, maxm) : m[i];
         if (neg[i]) begin
            if (v > 64'h8000_0000) v = 64'h8000_0000;
            o[i] = 32'(64'd0 - v);
         end else begin
            if (v > 64'h7fff_ffff) v = 64'h7fff_ffff;
            o[i] = v[31:0];
         end
      end
      r.fl = o[0];
      r.fr = o[1];
      r.rl = o[2];
      r.rr = o[3];
      return r;
   endfunction

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [30:0] d);
      case (idx)
         CSR_WHEEL_RADIUS: radius_q = d;
         CSR_BODY_LENGTH: length_q = d;
         CSR_BODY_WIDTH: width_q = d;
         CSR_SPEED_LIMIT: limit_q = d;
         CSR_GEAR_RATIO: gear_q = d;
         CSR_REVERSE_MASK: rev_mask = d[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic write_all(input logic [30:0] rad, input logic [30:0] len,
                            input logic [30:0] wid, input logic [30:0] lim,
                            input logic [30:0] gear, input logic [30:0] mask);
      csr_write(CSR_WHEEL_RADIUS, rad);
      csr_write(CSR_BODY_LENGTH, len);
      csr_write(CSR_BODY_WIDTH, wid);
      csr_write(CSR_SPEED_LIMIT, lim);
      csr_write(CSR_GEAR_RATIO, gear);
      csr_write(CSR_REVERSE_MASK, mask);
   endtask

   function automatic logic signed [31:0] rand_value();
      logic signed [31:0] edges[5] = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, 32'sh1,
                                       32'shffff_ffff};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
         5, 6: return $signed($urandom);
         7: return edges[$urandom_range(0, 4)];
         default: return $signed($urandom_range(0, 2000 * 65536)) - 1000 * 65536;
      endcase
   endfunction

   task automatic queue_random(input int n);
      velocity_cmd_type c;
      for (int i = 0; i < n; i++) begin
         c.vel_x = rand_value();
         c.vel_y = rand_value();
         c.yaw_rate = rand_value();
         c.heading = 16'($urandom);
         pending_cmds.insert(pending_cmds.size(), c);
      end
   endtask

   task automatic drain();
      while (pending_cmds.size() != 0 || start || expected_speeds.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   // item driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (gap > 0) begin
            gap <= gap - 1;
            start <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            gap <= $urandom_range(0, 16);
            start <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            start <= 1'b1;
            req_vel_x <= pending_cmds[0].vel_x;
            req_vel_y <= pending_cmds[0].vel_y;
            req_yaw_rate <= pending_cmds[0].yaw_rate;
            req_heading <= pending_cmds[0].heading;
            pending_cmds.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      velocity_cmd_type c;
      wheel_speeds_type e;
      taken <= start && !busy && !reset;
      if (start && !busy && !reset) begin
         c.vel_x = req_vel_x;
         c.vel_y = req_vel_y;
         c.yaw_rate = req_yaw_rate;
         c.heading = req_heading;
         expected_speeds.insert(expected_speeds.size(), predict_speeds(c));
      end
      if (rsp_valid && !reset) begin
         if (expected_speeds.size() == 0) begin
            $error("unexpected result item");
            fails++;
         end else begin
            e = expected_speeds.pop_front();
            if (rsp_speed_front_left !== e.fl) begin
               $error("speed_front_left expected %0d actual %0d", e.fl, rsp_speed_front_left);
               fails++;
            end
            if (rsp_speed_front_right !== e.fr) begin
               $error("speed_front_right expected %0d actual %0d", e.fr,
                      rsp_speed_front_right);
               fails++;
            end
            if (rsp_speed_rear_left !== e.rl) begin
               $error("speed_rear_left expected %0d actual %0d", e.rl, rsp_speed_rear_left);
               fails++;
            end
            if (rsp_speed_rear_right !== e.rr) begin
               $error("speed_rear_right expected %0d actual %0d", e.rr, rsp_speed_rear_right);
               fails++;
            end
            if (rsp_limited !== e.lim) begin
               $error("limited expected %0d actual %0d", e.lim, rsp_limited);
               fails++;
            end
         end
      end
   end

   initial begin
      velocity_cmd_type c;
      logic signed [31:0] vals[6] = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0,
                                      32'sh0001_0000, 32'shffff_0000, 32'shffff_ffff};
      logic signed [15:0] hds[6] = '{16'sh0000, 16'sh4000, 16'sh8000, 16'sh7fff,
                                     16'shc000, 16'sh2000};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, cardinal headings and two others under reset defaults
      for (int i = 0; i < 18; i++) begin
         c.vel_x = vals[i % 6];
         c.vel_y = vals[(i + 2) % 6];
         c.yaw_rate = vals[(i / 3) % 6];
         c.heading = hds[i % 6];
         pending_cmds.insert(pending_cmds.size(), c);
      end
      queue_random(100);
      drain();

      // smallest nonzero divisor, largest body and limit, all wheels reversed
      write_all(31'd1, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'd1, 31'd15);
      queue_random(110);
      drain();

      // largest divisor, smallest nonzero limit
      write_all(31'h7fff_ffff, 31'd0, 31'd0, 31'd1, 31'h7fff_ffff, 31'd5);
      queue_random(110);
      drain();

      // zero speed limit
      write_all(31'd65536, 31'd32768, 31'd16384, 31'd0, 31'd65536, 31'd10);
      queue_random(110);
      drain();

      // zero wheel radius
      write_all(31'd0, 31'd1000, 31'd2000, 31'd6553600, 31'd65536, 31'd3);
      queue_random(110);
      drain();

      // zero gear ratio, writes to unused indexes, high mask bits dropped
      write_all(31'd6554, 31'd32768, 31'd16384, 31'd6553600, 31'd0, 31'h7fff_fff0);
      csr_write(3'd6, 31'h1234_5678);
      csr_write(3'd7, 31'h7fff_ffff);
      queue_random(110);
      drain();

      // random settings
      for (int k = 0; k < 2; k++) begin
         write_all(31'($urandom_range(1, 200000)), 31'($urandom_range(0, 200000)),
                   31'($urandom_range(0, 200000)), 31'($urandom_range(1, 50000000)),
                   31'($urandom_range(1, 400000)), 31'($urandom_range(0, 15)));
         queue_random(80);
         drain();
      end

      // back to defaults, no idling
      write_all(31'd6554, 31'd32768, 31'd16384, 31'd6553600, 31'd65536, 31'd0);
      quiet = 1'b1;
      queue_random(100);
      drain();

      if (fails == 0 && expected_speeds.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
